// ===== hw/rtl/crsdp_pkg.sv =====
// Shared constants, types and helper functions of the capacitated route split unit.
package crsdp_pkg;

    localparam int WINDOW_DEF = 128;
    localparam int COORD_W    = 16;
    localparam int LOAD_W     = 16;
    localparam int COST_W     = 32;
    localparam int SUM_W      = 32;
    localparam int IN_DATA_W  = 48;

    localparam logic [LOAD_W-1:0] CAPACITY_RESET = 16'd100;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP1 = 5'b00010,
        ST_PREP2 = 5'b00100,
        ST_PREP3 = 5'b01000,
        ST_DONE  = 5'b10000
    } ctrl_state_t;

    // Values broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic              shift;
        logic [COST_W-1:0] offset;
        logic [SUM_W-1:0]  load_now;
        logic [LOAD_W-1:0] capacity;
    } cell_bcast_t;

    function automatic logic [COORD_W:0] mag16(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] e;
        begin
            e = {v[COORD_W-1], v};
            return v[COORD_W-1] ? (~e + {{COORD_W{1'b0}}, 1'b1}) : e;
        end
    endfunction

    function automatic logic [COORD_W:0] mag17(input logic [COORD_W:0] v);
        logic [COORD_W:0] r;
        begin
            r = v[COORD_W] ? (~v + {{COORD_W{1'b0}}, 1'b1}) : v;
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/capacitated_route_split_dp_unit.sv =====
// Top level of the capacitated route split unit: sequence control and the row of cells.
// A request is accepted only when the unit is idle and not scanning.
// The running minimum moves one cell per cycle through the WINDOW-1 cells of the row,
// and a result is ready once it has passed the last cell.
// Reset clears control, capacity (to 100) and the sequence state; cell contents are not reset.
// The result register lets the next request be accepted while a result waits to be taken.
module capacitated_route_split_dp_unit #(
    parameter int WINDOW = crsdp_pkg::WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crsdp_pkg::LOAD_W-1:0]         cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: pos_x[15:0], pos_y[31:16], load[47:32].
    input  logic [crsdp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: start_case.
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: best_cost[31:0].
    output logic [crsdp_pkg::COST_W-1:0]         m_axis_tdata,
    // Fields from bit 0: window_clipped.
    output logic                                 m_axis_tuser
);

    localparam int NCELL  = WINDOW - 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int CNT_W  = (WINDOW > 2) ? $clog2(WINDOW - 1) : 1;
    localparam int CW     = crsdp_pkg::COORD_W;
    localparam int KW     = crsdp_pkg::COST_W;
    localparam int SW     = crsdp_pkg::SUM_W;
    localparam int LW     = crsdp_pkg::LOAD_W;

    crsdp_pkg::ctrl_state_t state_reg, state_next;

    logic [LW-1:0]     cap_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [KW-1:0]     pdist_reg;
    logic [SW-1:0]     pload_reg;
    logic [CW-1:0]     prev_x_reg;
    logic [CW-1:0]     prev_y_reg;
    logic [KW-1:0]     prev_best_reg;
    logic              m_valid_reg;

    logic [CW-1:0]     x_reg;
    logic [CW-1:0]     y_reg;
    logic [LW-1:0]     ld_reg;
    logic              start_reg;
    logic [CW+1:0]     absb_reg;
    logic [CW+1:0]     step_reg;
    logic [SW-1:0]     lb_now_reg;
    logic [KW-1:0]     best_init_reg;
    logic [KW-1:0]     offset_reg;
    logic [KW-1:0]     new_base_reg;
    logic [KW-1:0]     best_cost_reg;
    logic              clipped_reg;
    logic              scan_reg;

    logic              in_fire;
    logic              done_fire;
    logic              scan_last;
    logic              clip_now;
    logic [CW:0]       dx;
    logic [CW:0]       dy;
    logic [SW-1:0]     tail_load;

    crsdp_pkg::cell_bcast_t bc;

    logic [KW-1:0] base_w [NCELL];
    logic [SW-1:0] lbb_w  [NCELL];
    logic [KW-1:0] min_w  [NCELL];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == crsdp_pkg::ST_IDLE) && !scan_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign done_fire     = (state_reg == crsdp_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready);
    assign scan_last     = scan_reg && (cnt_reg == CNT_W'(WINDOW - 2));

    assign bc.shift    = done_fire;
    assign bc.offset   = offset_reg;
    assign bc.load_now = lb_now_reg;
    assign bc.capacity = cap_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                crsdp_cell u_cell (
                    .clk      (clk),
                    .bc       (bc),
                    .enable   (fill_reg > FILL_W'(gi)),
                    .base_in  (new_base_reg),
                    .lbb_in   (pload_reg),
                    .min_in   (best_init_reg),
                    .base_out (base_w[gi]),
                    .lbb_out  (lbb_w[gi]),
                    .min_out  (min_w[gi])
                );
            end
            else
            begin : g_body
                crsdp_cell u_cell (
                    .clk      (clk),
                    .bc       (bc),
                    .enable   (fill_reg > FILL_W'(gi)),
                    .base_in  (base_w[gi-1]),
                    .lbb_in   (lbb_w[gi-1]),
                    .min_in   (min_w[gi-1]),
                    .base_out (base_w[gi]),
                    .lbb_out  (lbb_w[gi]),
                    .min_out  (min_w[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        dx        = {x_reg[CW-1], x_reg} - {prev_x_reg[CW-1], prev_x_reg};
        dy        = {y_reg[CW-1], y_reg} - {prev_y_reg[CW-1], prev_y_reg};
        tail_load = lb_now_reg - lbb_w[NCELL-1];
        clip_now  = (fill_reg == FILL_W'(WINDOW))
                    && (tail_load <= {{(SW - LW){1'b0}}, cap_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crsdp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = crsdp_pkg::ST_PREP1;
                end
                else if (scan_last)
                begin
                    state_next = crsdp_pkg::ST_DONE;
                end
            end
            crsdp_pkg::ST_PREP1: state_next = crsdp_pkg::ST_PREP2;
            crsdp_pkg::ST_PREP2: state_next = crsdp_pkg::ST_PREP3;
            crsdp_pkg::ST_PREP3: state_next = crsdp_pkg::ST_IDLE;
            crsdp_pkg::ST_DONE:
            begin
                if (done_fire)
                begin
                    state_next = crsdp_pkg::ST_IDLE;
                end
            end
            default: state_next = crsdp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crsdp_pkg::ST_IDLE;
            cap_reg       <= crsdp_pkg::CAPACITY_RESET;
            cnt_reg       <= '0;
            scan_reg      <= 1'b0;
            fill_reg      <= '0;
            pdist_reg     <= '0;
            pload_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_best_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (state_reg == crsdp_pkg::ST_PREP3)
            begin
                scan_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (scan_last)
            begin
                scan_reg <= 1'b0;
            end
            else if (scan_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if ((state_reg == crsdp_pkg::ST_PREP1) && start_reg)
            begin
                fill_reg      <= '0;
                pload_reg     <= '0;
                prev_best_reg <= '0;
            end
            if (state_reg == crsdp_pkg::ST_PREP1)
            begin
                if (start_reg)
                begin
                    pdist_reg <= '0;
                end
            end
            else if (state_reg == crsdp_pkg::ST_PREP2)
            begin
                if (fill_reg != '0)
                begin
                    pdist_reg <= pdist_reg + KW'(step_reg);
                end
            end
            if (done_fire)
            begin
                prev_best_reg <= min_w[NCELL-1];
                pload_reg     <= lb_now_reg;
                prev_x_reg    <= x_reg;
                prev_y_reg    <= y_reg;
                if (fill_reg < FILL_W'(WINDOW))
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg     <= s_axis_tdata[CW-1:0];
            y_reg     <= s_axis_tdata[2*CW-1:CW];
            ld_reg    <= s_axis_tdata[2*CW+LW-1:2*CW];
            start_reg <= s_axis_tuser;
        end
        if (state_reg == crsdp_pkg::ST_PREP1)
        begin
            absb_reg <= {1'b0, crsdp_pkg::mag16(x_reg)} + {1'b0, crsdp_pkg::mag16(y_reg)};
            step_reg <= {1'b0, crsdp_pkg::mag17(dx)} + {1'b0, crsdp_pkg::mag17(dy)};
        end
        if (state_reg == crsdp_pkg::ST_PREP2)
        begin
            lb_now_reg    <= pload_reg + SW'(ld_reg);
            best_init_reg <= prev_best_reg + KW'({absb_reg, 1'b0});
        end
        if (state_reg == crsdp_pkg::ST_PREP3)
        begin
            offset_reg   <= pdist_reg + KW'(absb_reg);
            new_base_reg <= prev_best_reg + KW'(absb_reg) - pdist_reg;
        end
        if (done_fire)
        begin
            best_cost_reg <= min_w[NCELL-1];
            clipped_reg   <= clip_now;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = best_cost_reg;
    assign m_axis_tuser  = clipped_reg;

    a_accept_starts_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == crsdp_pkg::ST_PREP1))
        else $error("Accepted request did not start preparation.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == crsdp_pkg::ST_DONE))
        else $error("Result appeared without a finished scan.");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("Fill count passed the window size.");

    a_no_accept_while_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg |-> !s_axis_tready)
        else $error("Request accepted during a scan.");

endmodule

// ===== hw/rtl/crsdp_cell.sv =====
// One cell of the row: holds a past point and folds its trip cost into the running minimum.
module crsdp_cell (
    input  logic                                clk,
    input  crsdp_pkg::cell_bcast_t              bc,
    input  logic                                enable,
    input  logic [crsdp_pkg::COST_W-1:0]        base_in,
    input  logic [crsdp_pkg::SUM_W-1:0]         lbb_in,
    input  logic [crsdp_pkg::COST_W-1:0]        min_in,
    output logic [crsdp_pkg::COST_W-1:0]        base_out,
    output logic [crsdp_pkg::SUM_W-1:0]         lbb_out,
    output logic [crsdp_pkg::COST_W-1:0]        min_out
);

    logic [crsdp_pkg::COST_W-1:0] base_reg;
    logic [crsdp_pkg::SUM_W-1:0]  lbb_reg;
    logic [crsdp_pkg::COST_W-1:0] min_reg;
    logic [crsdp_pkg::COST_W-1:0] min_next;
    logic [crsdp_pkg::COST_W-1:0] cand;
    logic [crsdp_pkg::SUM_W-1:0]  trip_load;
    logic                         fits;

    always_comb
    begin
        cand      = base_reg + bc.offset;
        trip_load = bc.load_now - lbb_reg;
        fits      = trip_load <= {{(crsdp_pkg::SUM_W - crsdp_pkg::LOAD_W){1'b0}}, bc.capacity};
        if (enable && fits && (cand < min_in))
        begin
            min_next = cand;
        end
        else
        begin
            min_next = min_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc.shift)
        begin
            base_reg <= base_in;
            lbb_reg  <= lbb_in;
        end
        min_reg <= min_next;
    end

    assign base_out = base_reg;
    assign lbb_out  = lbb_reg;
    assign min_out  = min_reg;

endmodule

// ===== tb/tb_capacitated_route_split_dp_unit.sv =====
// Self-checking testbench for the capacitated route split unit with a scoreboard and random stalls.
`timescale 1ns / 100ps

module tb_capacitated_route_split_dp_unit;

    localparam int WINDOW = crsdp_pkg::WINDOW_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_POINTS = 950;

    typedef struct packed {
        logic [31:0] cost;
        logic        clipped;
    } route_result_t;

    class route_cost_board;
        logic [15:0]   capacity;
        logic [31:0]   base_cost [WINDOW];
        logic [31:0]   load_before [WINDOW];
        logic [31:0]   path_len;
        logic [31:0]   load_sum;
        logic [31:0]   best_so_far;
        int            last_x;
        int            last_y;
        int            fill;
        int            slot;
        int            errors;
        route_result_t cost_due [$];

        function new();
            capacity = crsdp_pkg::CAPACITY_RESET;
            path_len = '0;
            load_sum = '0;
            best_so_far = '0;
            last_x = 0;
            last_y = 0;
            fill = 0;
            slot = 0;
            errors = 0;
        endfunction

        function logic [31:0] abs_diff(int a, int b);
            int d;
            d = a - b;
            return (d < 0) ? -d : d;
        endfunction

        function void note_point(logic start, logic signed [15:0] x, logic signed [15:0] y,
                                 logic [15:0] load);
            logic [31:0]   reach;
            logic [31:0]   load_now;
            logic [31:0]   best;
            logic [31:0]   cand;
            int            span;
            int            k;
            int            idx;
            route_result_t r;
            if (start)
            begin
                path_len = '0;
                load_sum = '0;
                best_so_far = '0;
                fill = 0;
            end
            reach = abs_diff(int'(x), 0) + abs_diff(int'(y), 0);
            if (fill > 0)
                path_len = path_len + abs_diff(int'(x), last_x) + abs_diff(int'(y), last_y);
            load_now = load_sum + {16'd0, load};
            base_cost[slot] = best_so_far + reach - path_len;
            load_before[slot] = load_sum;
            best = best_so_far + reach + reach;
            span = (fill < WINDOW - 1) ? fill : WINDOW - 1;
            for (k = 1; k <= span; k++)
            begin
                idx = (slot + WINDOW - k) % WINDOW;
                if (load_now - load_before[idx] <= {16'd0, capacity})
                begin
                    cand = base_cost[idx] + path_len + reach;
                    if (cand < best)
                        best = cand;
                end
            end
            r.clipped = 1'b0;
            if (fill >= WINDOW)
            begin
                idx = (slot + 1) % WINDOW;
                if (load_now - load_before[idx] <= {16'd0, capacity})
                    r.clipped = 1'b1;
            end
            r.cost = best;
            cost_due.push_back(r);
            best_so_far = best;
            load_sum = load_now;
            last_x = int'(x);
            last_y = int'(y);
            slot = (slot + 1) % WINDOW;
            if (fill < WINDOW)
                fill++;
        endfunction

        function void check_result(logic [31:0] cost, logic clipped);
            route_result_t r;
            if (cost_due.size() == 0)
            begin
                $error("unexpected result: best_cost=%0d window_clipped=%0b", cost, clipped);
                errors++;
                return;
            end
            r = cost_due.pop_front();
            if (cost !== r.cost)
            begin
                $error("best_cost mismatch: expected %0d, actual %0d", r.cost, cost);
                errors++;
            end
            if (clipped !== r.clipped)
            begin
                $error("window_clipped mismatch: expected %0b, actual %0b", r.clipped, clipped);
                errors++;
            end
        endfunction

        function int pending();
            return cost_due.size();
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [crsdp_pkg::LOAD_W-1:0]       cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [crsdp_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                               s_axis_tuser = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [crsdp_pkg::COST_W-1:0]       m_axis_tdata;
    logic                               m_axis_tuser;

    route_cost_board board = new();
    int  points_sent = 0;
    int  cur_cap = int'(crsdp_pkg::CAPACITY_RESET);
    bit  steady_in = 1'b0;

    capacitated_route_split_dp_unit #(
        .WINDOW(WINDOW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.capacity = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                board.note_point(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                                 s_axis_tdata[47:32]);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 250);
    endfunction

    function automatic logic [15:0] pick_corner();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic int pick_capacity(int phase);
        case (phase % 8)
            0: return 0;
            1: return 65535;
            2: return 1;
            4: return 65535;
            5: return int'(crsdp_pkg::CAPACITY_RESET);
            6: return $urandom_range(2, 600);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic send_point(logic start, logic [15:0] x, logic [15:0] y, logic [15:0] load);
        int gap;
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {load, y, x};
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        points_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (WINDOW + 8) @(posedge clk);
    endtask

    task automatic write_capacity(int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_cap = value;
    endtask

    task automatic run_route(int length, int coord_style, int load_style);
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] ld;
        logic        start;
        int          i;
        steady_in = ($urandom_range(0, 3) == 0);
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (i = 0; i < length; i++)
        begin
            start = (i == 0) || ($urandom_range(0, 39) == 0);
            case (coord_style)
                0:
                begin
                    px = 16'($urandom_range(0, 120) - 60);
                    py = 16'($urandom_range(0, 120) - 60);
                end
                1:
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                2:
                begin
                    px = pick_corner();
                    py = pick_corner();
                end
                default:
                begin
                    px = 16'(cx + $urandom_range(0, 600) - 300);
                    py = 16'(cy + $urandom_range(0, 600) - 300);
                end
            endcase
            case (load_style)
                0: ld = 16'($urandom_range(0, cur_cap / 8));
                1: ld = 16'($urandom_range(0, cur_cap));
                2: ld = 16'($urandom);
                3: ld = $urandom_range(0, 1) ? 16'(cur_cap) : 16'd0;
                default: ld = 16'($urandom_range(0, cur_cap / 256));
            endcase
            send_point(start, px, py, ld);
        end
    endtask

    initial
    begin : result_ready_pattern
        int stall;
        int run;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 30);
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** capacitated_route_split_dp_unit: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int goal;
        int phase_end;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first points carry no start mark: the cleared state acts as a new sequence.
        send_point(1'b0, 16'h0000, 16'h0000, 16'd0);
        send_point(1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_point(1'b0, 16'h8000, 16'h8000, 16'd0);
        send_point(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_point(1'b0, 16'h7FFF, 16'h8000, 16'd100);
        send_point(1'b1, 16'd5, -16'sd7, 16'd40);
        send_point(1'b0, 16'd6, -16'sd8, 16'd60);
        send_point(1'b0, -16'sd3, 16'd4, 16'd1);
        send_point(1'b0, -16'sd3, 16'd4, 16'd0);
        send_point(1'b0, 16'h0000, 16'h0000, 16'd0);
        send_point(1'b1, 16'hFFFF, 16'hFFFF, 16'd100);
        send_point(1'b1, 16'd10, 16'd10, 16'd101);
        send_point(1'b0, 16'd10, 16'd11, 16'd0);
        send_point(1'b0, 16'd10, 16'd12, 16'd0);
        send_point(1'b0, 16'd0, 16'd1, 16'hFFFF);
        send_point(1'b1, 16'h7FFF, 16'h0000, 16'd1);
        send_point(1'b0, 16'h8000, 16'h0000, 16'd1);

        goal = points_sent + RANDOM_POINTS;
        phase = 0;
        while (points_sent < goal)
        begin
            write_capacity(pick_capacity(phase));
            if (phase % 3 == 1)
                run_route(WINDOW + $urandom_range(5, 60), $urandom_range(0, 3),
                          (phase == 1) ? 4 : $urandom_range(0, 4));
            phase_end = points_sent + 110;
            while (points_sent < phase_end && points_sent < goal)
                run_route(($urandom_range(0, 3) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(1, 12),
                          $urandom_range(0, 3), $urandom_range(0, 4));
            phase++;
        end

        wait_drained();
        if (board.errors == 0)
            $display("** capacitated_route_split_dp_unit: PASSED **");
        else
            $display("** capacitated_route_split_dp_unit: FAILED **");
        $finish;
    end

endmodule
